[hw/rtl/qalu_pkg.sv]
package qalu_pkg;

    // component format
    localparam int CB = 16;                 // component bits
    localparam int FB = 12;                 // fraction bits
    localparam int PW = 2 * CB;             // product width
    localparam int HW = PW + 3;             // sum of four products plus rounding
    localparam int SW = 2 * CB + 1;         // exact sum of four squares
    localparam int NORMW = 32;              // norm output width
    localparam int RTB = (SW + 1) / 2;      // root bits
    localparam int RMW = RTB + 3;           // root remainder width
    localparam int NFW = SW - FB + 1;       // rounded norm divisor width
    localparam int DW0 = (NFW > RTB) ? NFW : RTB;
    localparam int DW = (DW0 > CB) ? DW0 : CB;  // divisor width
    localparam int NW = CB + FB + 2;        // dividend width
    localparam int QW = NW;                 // quotient width / divider stages
    localparam int LATENCY = 4 + RTB + QW;

    localparam logic signed [HW-1:0] HALF_H = {{(HW-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};
    localparam logic [CB-1:0] CMAX_U = {1'b0, {(CB-1){1'b1}}};
    localparam logic [CB-1:0] CMIN_U = {1'b1, {(CB-1){1'b0}}};

    typedef logic signed [CB-1:0] t_comp;

    typedef enum logic [2:0] {
        K_ADD, K_SUB, K_MUL, K_CONJ, K_SCALE, K_DIV, K_NORM, K_INV
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK, ST_SAT, ST_DIVZ
    } t_status;

    typedef struct packed {
        t_kind kind;
        t_comp a_w;
        t_comp a_x;
        t_comp a_y;
        t_comp a_z;
        t_comp b_w;
        t_comp b_x;
        t_comp b_y;
        t_comp b_z;
        t_comp scalar;
    } t_in;

    typedef struct packed {
        t_comp            r_w;
        t_comp            r_x;
        t_comp            r_y;
        t_comp            r_z;
        logic [NORMW-1:0] norm_squared;
        t_status          status;
    } t_out;

    // front end result: direct results already saturated, plus what the divide path needs
    typedef struct packed {
        logic                  valid;
        t_kind                 kind;
        logic [3:0][CB-1:0]    a;
        logic [CB-1:0]         sc;
        logic [3:0][CB-1:0]    r;
        logic                  flag;
        logic [SW-1:0]         s;
    } t_front;

    // side data carried along the divider
    typedef struct packed {
        logic                  valid;
        t_kind                 kind;
        logic [3:0][CB-1:0]    r;
        logic                  flag;
        logic [NORMW-1:0]      norm;
        logic                  dz;
        logic [3:0]            neg;
    } t_side;

    typedef struct packed {
        logic  flag;
        t_comp val;
    } t_sat;

    function automatic t_sat sat_comp(input logic signed [HW-1:0] v);
        t_sat res;
        res.flag = !((&v[HW-1:CB-1]) || !(|v[HW-1:CB-1]));
        if (res.flag) begin
            res.val = v[HW-1] ? t_comp'(CMIN_U) : t_comp'(CMAX_U);
        end else begin
            res.val = v[CB-1:0];
        end
        return res;
    endfunction

endpackage

[hw/rtl/qalu_front.sv]
module qalu_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  qalu_pkg::t_in    i_in,
    output qalu_pkg::t_front o_front
);
    import qalu_pkg::*;

    logic                  r_v0;
    t_in                   r_in;
    logic                  r_v1;
    t_kind                 r_kind1;
    logic [3:0][CB-1:0]    r_a1;
    logic [3:0][CB-1:0]    r_b1;
    logic [CB-1:0]         r_sc1;
    logic signed [PW-1:0]  r_pp [4][4];
    logic signed [PW-1:0]  r_sq [4];
    logic signed [PW-1:0]  r_ps [4];
    logic [3:0][CB-1:0]    av;
    logic [3:0][CB-1:0]    bv;
    t_front                n_f;
    t_front                r_f;

    assign av = {r_in.a_z, r_in.a_y, r_in.a_x, r_in.a_w};
    assign bv = {r_in.b_z, r_in.b_y, r_in.b_x, r_in.b_w};

    // stage 0: input register
    always_ff @(posedge i_clk) begin
        r_in <= i_in;
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= i_valid;
        end
    end

    // stage 1: all products
    always_ff @(posedge i_clk) begin
        r_kind1 <= r_in.kind;
        r_a1    <= av;
        r_b1    <= bv;
        r_sc1   <= r_in.scalar;
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                r_pp[i][j] <= $signed(av[i]) * $signed(bv[j]);
            end
            r_sq[i] <= $signed(av[i]) * $signed(av[i]);
            r_ps[i] <= $signed(av[i]) * $signed(r_in.scalar);
        end
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= r_v0;
        end
    end

    // stage 2: sums, rounding, saturation
    always_comb begin
        logic signed [HW-1:0] hm [4];
        logic signed [HW-1:0] hv;
        logic signed [HW-1:0] ae;
        logic signed [HW-1:0] be;
        t_sat                 st;
        hm[0] = HW'(r_pp[0][0]) - HW'(r_pp[1][1]) - HW'(r_pp[2][2]) - HW'(r_pp[3][3]);
        hm[1] = HW'(r_pp[0][1]) + HW'(r_pp[1][0]) + HW'(r_pp[2][3]) - HW'(r_pp[3][2]);
        hm[2] = HW'(r_pp[0][2]) + HW'(r_pp[2][0]) + HW'(r_pp[3][1]) - HW'(r_pp[1][3]);
        hm[3] = HW'(r_pp[0][3]) + HW'(r_pp[3][0]) + HW'(r_pp[1][2]) - HW'(r_pp[2][1]);
        n_f.valid = r_v1;
        n_f.kind  = r_kind1;
        n_f.a     = r_a1;
        n_f.sc    = r_sc1;
        n_f.flag  = 1'b0;
        n_f.r     = '0;
        for (int i = 0; i < 4; i++) begin
            ae = HW'($signed(r_a1[i]));
            be = HW'($signed(r_b1[i]));
            case (r_kind1)
                K_ADD:   hv = ae + be;
                K_SUB:   hv = ae - be;
                K_MUL:   hv = (hm[i] + HALF_H) >>> FB;
                K_CONJ:  hv = (i == 0) ? ae : -ae;
                K_SCALE: hv = (HW'(r_ps[i]) + HALF_H) >>> FB;
                default: hv = '0;
            endcase
            st = sat_comp(hv);
            n_f.r[i] = st.val;
            n_f.flag = n_f.flag | st.flag;
        end
        n_f.s = SW'(r_sq[0][PW-1:0]) + SW'(r_sq[1][PW-1:0])
              + SW'(r_sq[2][PW-1:0]) + SW'(r_sq[3][PW-1:0]);
    end

    always_ff @(posedge i_clk) begin
        r_f <= n_f;
        if (!i_rst_n) begin
            r_f.valid <= 1'b0;
        end
    end

    assign o_front = r_f;

endmodule

[hw/rtl/qalu_sqrt.sv]
module qalu_sqrt (
    input  logic                     i_clk,
    input  logic [qalu_pkg::SW-1:0]  i_x,
    output logic [qalu_pkg::RTB-1:0] o_root
);
    import qalu_pkg::*;

    // one root bit per stage, two radicand bits consumed per stage
    logic [2*RTB-1:0] r_x    [RTB];
    logic [RMW-1:0]   r_rem  [RTB];
    logic [RTB-1:0]   r_root [RTB];
    logic [2*RTB-1:0] n_x    [RTB];
    logic [RMW-1:0]   n_rem  [RTB];
    logic [RTB-1:0]   n_root [RTB];

    always_comb begin
        logic [2*RTB-1:0] cx;
        logic [RMW-1:0]   crem;
        logic [RTB-1:0]   croot;
        logic [RMW-1:0]   trem;
        logic [RMW-1:0]   trial;
        for (int k = 0; k < RTB; k++) begin
            if (k == 0) begin
                cx    = {1'b0, i_x};
                crem  = '0;
                croot = '0;
            end else begin
                cx    = r_x[k-1];
                crem  = r_rem[k-1];
                croot = r_root[k-1];
            end
            trem  = {crem[RMW-3:0], cx[2*RTB-1 -: 2]};
            trial = RMW'({croot, 2'b01});
            if (trem >= trial) begin
                n_rem[k]  = trem - trial;
                n_root[k] = {croot[RTB-2:0], 1'b1};
            end else begin
                n_rem[k]  = trem;
                n_root[k] = {croot[RTB-2:0], 1'b0};
            end
            n_x[k] = {cx[2*RTB-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < RTB; k++) begin
            r_x[k]    <= n_x[k];
            r_rem[k]  <= n_rem[k];
            r_root[k] <= n_root[k];
        end
    end

    assign o_root = r_root[RTB-1];

endmodule

[hw/rtl/qalu_div.sv]
module qalu_div (
    input  logic                              i_clk,
    input  logic [3:0][qalu_pkg::NW-1:0]      i_num,
    input  logic [qalu_pkg::DW:0]             i_den,
    output logic [3:0][qalu_pkg::QW-1:0]      o_quo
);
    import qalu_pkg::*;

    // restoring division, one quotient bit per stage, four lanes on one divisor
    logic [3:0][NW-1:0] r_n   [QW];
    logic [3:0][DW:0]   r_rem [QW];
    logic [3:0][QW-1:0] r_q   [QW];
    logic [DW:0]        r_d   [QW];
    logic [3:0][NW-1:0] n_n   [QW];
    logic [3:0][DW:0]   n_rem [QW];
    logic [3:0][QW-1:0] n_q   [QW];
    logic [DW:0]        n_d   [QW];

    always_comb begin
        logic [3:0][NW-1:0] cn;
        logic [3:0][DW:0]   crem;
        logic [3:0][QW-1:0] cq;
        logic [DW:0]        cd;
        logic [DW+1:0]      trem;
        for (int k = 0; k < QW; k++) begin
            if (k == 0) begin
                cn   = i_num;
                crem = '0;
                cq   = '0;
                cd   = i_den;
            end else begin
                cn   = r_n[k-1];
                crem = r_rem[k-1];
                cq   = r_q[k-1];
                cd   = r_d[k-1];
            end
            n_d[k] = cd;
            for (int l = 0; l < 4; l++) begin
                trem = {crem[l], cn[l][NW-1]};
                if (trem >= {1'b0, cd}) begin
                    n_rem[k][l] = (DW+1)'(trem - {1'b0, cd});
                    n_q[k][l]   = {cq[l][QW-2:0], 1'b1};
                end else begin
                    n_rem[k][l] = (DW+1)'(trem);
                    n_q[k][l]   = {cq[l][QW-2:0], 1'b0};
                end
                n_n[k][l] = {cn[l][NW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < QW; k++) begin
            r_n[k]   <= n_n[k];
            r_rem[k] <= n_rem[k];
            r_q[k]   <= n_q[k];
            r_d[k]   <= n_d[k];
        end
    end

    assign o_quo = r_q[QW-1];

endmodule

[hw/rtl/quaternion_alu_top.sv]
// Fixed-point quaternion unit, signed Q3.12 components, no kept state.
//
// Input channel: a transaction is accepted at a rising edge with start high and
// busy low. busy is always low, so one transaction may enter every cycle.
// Payload i_op carries the operation code, quaternions A and B and the scalar.
//
// Output channel: o_strobe is high for exactly one cycle with o_res holding the
// result quaternion, the saturated squared norm of A and the status. The
// receiver cannot hold results off, and none is needed: the pipeline never
// stalls and results come out in the order transactions went in.
//
// The delay from the accepting edge to the strobe cycle is the same for every
// operation code. Most of it comes from the 17-stage root pipeline (one root
// bit per stage) followed by the 30-stage divider (one quotient bit per stage,
// four lanes). Throughput: one transaction per cycle.
//
// Reset (synchronous, active low) clears every valid bit; results of
// transactions in flight are dropped.
module quaternion_alu_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  qalu_pkg::t_in     i_op,
    output logic              o_strobe,
    output qalu_pkg::t_out    o_res
);
    import qalu_pkg::*;

    t_front             front;
    logic [RTB-1:0]     root;
    t_front             r_fd [RTB];     // front data waiting on the root
    t_side              n_side;
    t_side              r_side;
    logic [3:0][NW-1:0] n_num;
    logic [3:0][NW-1:0] r_num;
    logic [DW:0]        n_den;
    logic [DW:0]        r_den;
    t_side              r_sd [QW];      // side data waiting on the divider
    logic [3:0][QW-1:0] quo;
    t_out               n_out;
    t_out               r_out;
    logic               r_strobe;

    assign busy = 1'b0;

    qalu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_in    (i_op),
        .o_front (front)
    );

    qalu_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_x    (front.s),
        .o_root (root)
    );

    always_ff @(posedge i_clk) begin
        r_fd[0] <= front;
        for (int k = 1; k < RTB; k++) begin
            r_fd[k] <= r_fd[k-1];
        end
        if (!i_rst_n) begin
            for (int k = 0; k < RTB; k++) begin
                r_fd[k].valid <= 1'b0;
            end
        end
    end

    // divider setup: pick divisor, build rounded dividends 2n+d over 2d
    always_comb begin
        t_front             f;
        logic [DW-1:0]      nf;
        logic [DW-1:0]      d;
        logic [CB-1:0]      scm;
        logic [CB-1:0]      mag;
        logic               isdiv;
        logic               numneg;
        f   = r_fd[RTB-1];
        nf  = DW'(f.s >> FB) + DW'(f.s[FB-1]);
        scm = f.sc[CB-1] ? CB'(-f.sc) : f.sc;
        case (f.kind)
            K_DIV:   d = DW'(scm);
            K_NORM:  d = DW'(root);
            K_INV:   d = nf;
            default: d = '1;
        endcase
        isdiv = (f.kind == K_DIV) || (f.kind == K_NORM) || (f.kind == K_INV);
        n_side.valid = f.valid;
        n_side.kind  = f.kind;
        n_side.r     = f.r;
        n_side.flag  = f.flag;
        n_side.norm  = (|f.s[SW-1:NORMW]) ? '1 : f.s[NORMW-1:0];
        n_side.dz    = isdiv && (d == '0);
        for (int l = 0; l < 4; l++) begin
            mag    = f.a[l][CB-1] ? CB'(-f.a[l]) : f.a[l];
            numneg = f.a[l][CB-1] ^ ((f.kind == K_INV) && (l != 0));
            n_side.neg[l] = numneg ^ ((f.kind == K_DIV) && f.sc[CB-1]);
            n_num[l] = (NW'(mag) << (FB + 1)) + NW'(d);
        end
        n_den = {d, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        r_side <= n_side;
        r_num  <= n_num;
        r_den  <= n_den;
        if (!i_rst_n) begin
            r_side.valid <= 1'b0;
        end
    end

    qalu_div u_div (
        .i_clk (i_clk),
        .i_num (r_num),
        .i_den (r_den),
        .o_quo (quo)
    );

    always_ff @(posedge i_clk) begin
        r_sd[0] <= r_side;
        for (int k = 1; k < QW; k++) begin
            r_sd[k] <= r_sd[k-1];
        end
        if (!i_rst_n) begin
            for (int k = 0; k < QW; k++) begin
                r_sd[k].valid <= 1'b0;
            end
        end
    end

    // final select, sign and saturation of quotients
    always_comb begin
        t_side              sd;
        logic [3:0][CB-1:0] rr;
        logic               flag;
        logic               isdiv;
        sd    = r_sd[QW-1];
        rr    = sd.r;
        flag  = sd.flag;
        isdiv = (sd.kind == K_DIV) || (sd.kind == K_NORM) || (sd.kind == K_INV);
        if (isdiv) begin
            flag = 1'b0;
            for (int l = 0; l < 4; l++) begin
                if (sd.dz) begin
                    rr[l] = '0;
                end else if (sd.neg[l]) begin
                    if (quo[l] > {{(QW-CB){1'b0}}, CMIN_U}) begin
                        rr[l] = CMIN_U;
                        flag  = 1'b1;
                    end else begin
                        rr[l] = CB'(-quo[l][CB-1:0]);
                    end
                end else begin
                    if (quo[l] > {{(QW-CB){1'b0}}, CMAX_U}) begin
                        rr[l] = CMAX_U;
                        flag  = 1'b1;
                    end else begin
                        rr[l] = quo[l][CB-1:0];
                    end
                end
            end
        end
        n_out.r_w          = rr[0];
        n_out.r_x          = rr[1];
        n_out.r_y          = rr[2];
        n_out.r_z          = rr[3];
        n_out.norm_squared = sd.norm;
        if (sd.dz) begin
            n_out.status = ST_DIVZ;
        end else if (flag) begin
            n_out.status = ST_SAT;
        end else begin
            n_out.status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_sd[QW-1].valid;
        end
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_out;

endmodule

[verif/quaternion_alu_top_tb.sv]
module quaternion_alu_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qalu_pkg::*;

    // Pipeline depth from the accepting edge to the strobe cycle.
    localparam int PIPE_DEPTH = LATENCY;
    localparam int RANDOM_OPS = 925;
    localparam longint QONE = 64'sd4096;
    localparam longint QHALF = 64'sd2048;
    localparam longint CMAXV = 64'sd32767;
    localparam longint CMINV = -64'sd32768;

    logic   i_clk;
    logic   i_rst_n;
    logic   start;
    logic   busy;
    t_in    i_op;
    logic   o_strobe;
    t_out   o_res;

    quaternion_alu_top DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_op     (i_op),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

    // Results we are still waiting for, oldest first.
    t_out   pending_results[$];
    int     mismatch_count;
    int     result_count;
    int     op_count;
    bit     kind_seen[8];

    // One directed transaction and, where it can be read off at a glance, its
    // expected result. Rows without has_expect go through the predictor only.
    typedef struct {
        t_in    op;
        bit     has_expect;
        t_out   expect_res;
    } t_row;

    t_row   directed_rows[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("CHECK FAILED");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Quaternion arithmetic predictor
    // ---------------------------------------------------------------------

    function automatic longint shift_floor(input longint p);
        return p >>> 12;
    endfunction

    // Sum of four exact products, divided by 2^12, rounded half up.
    function automatic longint round_prod4(input longint p0, input longint p1,
                                           input longint p2, input longint p3);
        longint total;
        total = p0 + p1 + p2 + p3;
        return shift_floor(total + QHALF);
    endfunction

    // num * 2^12 / d, nearest, ties away from zero; d > 0.
    function automatic longint round_quot(input longint num, input longint d,
                                          input bit dneg);
        longint n;
        longint q;
        n = (num < 0 ? -num : num) <<< 12;
        q = (2 * n + d) / (2 * d);
        return (((num < 0) != dneg) ? -q : q);
    endfunction

    function automatic longint int_sqrt(input longint x);
        longint root;
        longint bitv;
        root = 0;
        bitv = 64'sd1 <<< 62;
        while (bitv > x) bitv = bitv >>> 2;
        while (bitv != 0) begin
            if (x >= root + bitv) begin
                x = x - (root + bitv);
                root = (root >>> 1) + bitv;
            end else begin
                root = root >>> 1;
            end
            bitv = bitv >>> 2;
        end
        return root;
    endfunction

    function automatic t_out predict_quat(input t_in op);
        longint a[4];
        longint b[4];
        longint r[4];
        longint sc;
        longint sumsq;
        longint m;
        longint nf;
        bit     clipped;
        bit     divz;
        t_out   res;
        a[0] = op.a_w; a[1] = op.a_x; a[2] = op.a_y; a[3] = op.a_z;
        b[0] = op.b_w; b[1] = op.b_x; b[2] = op.b_y; b[3] = op.b_z;
        sc = op.scalar;
        clipped = 1'b0;
        divz = 1'b0;
        sumsq = 0;
        for (int i = 0; i < 4; i++) begin
            r[i] = 0;
            sumsq += a[i] * a[i];
        end
        case (op.kind)
            K_ADD: for (int i = 0; i < 4; i++) r[i] = a[i] + b[i];
            K_SUB: for (int i = 0; i < 4; i++) r[i] = a[i] - b[i];
            K_MUL: begin
                r[0] = round_prod4(a[0]*b[0], -(a[1]*b[1]), -(a[2]*b[2]), -(a[3]*b[3]));
                r[1] = round_prod4(a[0]*b[1], b[0]*a[1], a[2]*b[3], -(a[3]*b[2]));
                r[2] = round_prod4(a[0]*b[2], b[0]*a[2], a[3]*b[1], -(a[1]*b[3]));
                r[3] = round_prod4(a[0]*b[3], b[0]*a[3], a[1]*b[2], -(a[2]*b[1]));
            end
            K_CONJ: begin
                r[0] = a[0];
                for (int i = 1; i < 4; i++) r[i] = -a[i];
            end
            K_SCALE: for (int i = 0; i < 4; i++) r[i] = round_prod4(a[i] * sc, 0, 0, 0);
            K_DIV: begin
                if (sc == 0) begin
                    divz = 1'b1;
                end else begin
                    for (int i = 0; i < 4; i++)
                        r[i] = round_quot(a[i], (sc < 0) ? -sc : sc, sc < 0);
                end
            end
            K_NORM: begin
                m = int_sqrt(sumsq);
                if (m == 0) begin
                    divz = 1'b1;
                end else begin
                    for (int i = 0; i < 4; i++) r[i] = round_quot(a[i], m, 1'b0);
                end
            end
            default: begin
                // Divisor is the squared norm brought back to 12 fraction bits.
                nf = (sumsq >>> 12) + ((sumsq >>> 11) & 1);
                if (nf == 0) begin
                    divz = 1'b1;
                end else begin
                    r[0] = round_quot(a[0], nf, 1'b0);
                    for (int i = 1; i < 4; i++) r[i] = round_quot(-a[i], nf, 1'b0);
                end
            end
        endcase
        if (divz) begin
            for (int i = 0; i < 4; i++) r[i] = 0;
        end
        for (int i = 0; i < 4; i++) begin
            if (r[i] > CMAXV) begin
                r[i] = CMAXV;
                clipped = 1'b1;
            end else if (r[i] < CMINV) begin
                r[i] = CMINV;
                clipped = 1'b1;
            end
        end
        res.r_w = t_comp'(r[0]);
        res.r_x = t_comp'(r[1]);
        res.r_y = t_comp'(r[2]);
        res.r_z = t_comp'(r[3]);
        res.norm_squared = (sumsq > 64'sh0FFFF_FFFF) ? 32'hFFFF_FFFF : sumsq[31:0];
        res.status = divz ? ST_DIVZ : (clipped ? ST_SAT : ST_OK);
        return res;
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------

    function automatic t_comp rand_comp();
        // Bias toward the extremes and toward small values so saturation,
        // zero divisors and ordinary values all show up.
        case ($urandom_range(0, 9))
            0: return t_comp'(CMAX_U);
            1: return t_comp'(CMIN_U);
            2: return t_comp'(0);
            3: return t_comp'($urandom_range(0, 8) - 4);
            4, 5: return t_comp'(int'($urandom_range(0, 16384)) - 8192);
            default: return t_comp'($urandom);
        endcase
    endfunction

    function automatic t_in rand_op();
        t_in op;
        op.kind = t_kind'($urandom_range(0, 7));
        op.a_w = rand_comp();
        op.a_x = rand_comp();
        op.a_y = rand_comp();
        op.a_z = rand_comp();
        op.b_w = rand_comp();
        op.b_x = rand_comp();
        op.b_y = rand_comp();
        op.b_z = rand_comp();
        op.scalar = rand_comp();
        return op;
    endfunction

    function automatic t_in make_op(input t_kind k, input t_comp aw, input t_comp ax,
                                    input t_comp ay, input t_comp az, input t_comp bw,
                                    input t_comp bx, input t_comp by, input t_comp bz,
                                    input t_comp sc);
        t_in op;
        op.kind = k;
        op.a_w = aw; op.a_x = ax; op.a_y = ay; op.a_z = az;
        op.b_w = bw; op.b_x = bx; op.b_y = by; op.b_z = bz;
        op.scalar = sc;
        return op;
    endfunction

    function automatic t_out make_res(input t_comp rw, input t_comp rx, input t_comp ry,
                                      input t_comp rz, input logic [31:0] nsq,
                                      input t_status st);
        t_out res;
        res.r_w = rw; res.r_x = rx; res.r_y = ry; res.r_z = rz;
        res.norm_squared = nsq;
        res.status = st;
        return res;
    endfunction

    function automatic void add_row(input t_in op, input bit has_expect, input t_out exp_res);
        t_row row;
        row.op = op;
        row.has_expect = has_expect;
        row.expect_res = exp_res;
        directed_rows.push_back(row);
    endfunction

    // Drive one transaction and hold start until the block takes it.
    // Driving happens at the rising edge, nonblocking, so the DUT samples
    // stable values at the next edge.
    task automatic send_op(input t_in op, input bit has_expect, input t_out exp_res);
        t_out model_res;
        model_res = predict_quat(op);
        if (has_expect && model_res !== exp_res) begin
            $display("Directed row disagrees with predictor: kind %s", op.kind.name());
        end
        start <= 1'b1;
        i_op <= op;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        // Accepted at this edge: queue the expectation now, before the strobe.
        pending_results.push_back(has_expect ? exp_res : model_res);
        kind_seen[op.kind] = 1'b1;
        op_count++;
    endtask

    task automatic idle_cycles(input int n);
        logic [159:0] noise;
        noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
        start <= 1'b0;
        i_op <= noise[$bits(t_in)-1:0];
        repeat (n) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------------
    // Result checker: one strobe is one result transaction.
    // ---------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            result_count++;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result: %p", o_res);
            end else begin
                t_out exp_res;
                exp_res = pending_results.pop_front();
                if (o_res.r_w !== exp_res.r_w || o_res.r_x !== exp_res.r_x ||
                    o_res.r_y !== exp_res.r_y || o_res.r_z !== exp_res.r_z ||
                    o_res.norm_squared !== exp_res.norm_squared ||
                    o_res.status !== exp_res.status) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("Mismatch at result %0d", result_count);
                        $display("  expected %p", exp_res);
                        $display("  actual   %p", o_res);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------

    initial begin
        int burst;
        int wait_cycles;
        t_out none_res;
        t_comp zr;
        t_comp one;
        t_comp cmax;
        t_comp cmin;

        zr = t_comp'(0);
        one = t_comp'(QONE);
        cmax = t_comp'(CMAX_U);
        cmin = t_comp'(CMIN_U);
        none_res = '0;
        mismatch_count = 0;
        result_count = 0;
        op_count = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_op = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows: extremes, every operation code, zero divisors,
        // conjugate of the minimum, saturation on add and product.
        add_row(make_op(K_ADD, zr, zr, zr, zr, zr, zr, zr, zr, zr), 1,
                make_res(zr, zr, zr, zr, 32'd0, ST_OK));
        add_row(make_op(K_ADD, cmax, cmax, cmax, cmax, cmax, cmax, cmax, cmax, zr), 1,
                make_res(cmax, cmax, cmax, cmax, 32'hFFFC_0004, ST_SAT));
        add_row(make_op(K_SUB, cmin, cmin, cmin, cmin, cmax, cmax, cmax, cmax, zr), 1,
                make_res(cmin, cmin, cmin, cmin, 32'hFFFF_FFFF, ST_SAT));
        add_row(make_op(K_CONJ, cmin, cmin, zr, one, zr, zr, zr, zr, zr), 1,
                make_res(cmin, cmax, zr, t_comp'(-QONE), 32'h8100_0000, ST_SAT));
        add_row(make_op(K_DIV, one, zr, zr, zr, zr, zr, zr, zr, zr), 1,
                make_res(zr, zr, zr, zr, 32'h0100_0000, ST_DIVZ));
        add_row(make_op(K_NORM, zr, zr, zr, zr, cmax, cmin, one, one, one), 1,
                make_res(zr, zr, zr, zr, 32'd0, ST_DIVZ));
        add_row(make_op(K_INV, zr, t_comp'(1), zr, zr, zr, zr, zr, zr, zr), 1,
                make_res(zr, zr, zr, zr, 32'd1, ST_DIVZ));
        add_row(make_op(K_MUL, one, zr, zr, zr, one, zr, zr, zr, zr), 1,
                make_res(one, zr, zr, zr, 32'h0100_0000, ST_OK));
        add_row(make_op(K_SCALE, one, one, one, one, zr, zr, zr, zr, one), 1,
                make_res(one, one, one, one, 32'h0400_0000, ST_OK));
        add_row(make_op(K_MUL, cmin, cmin, cmin, cmin, cmin, cmax, cmin, cmax, zr), 0,
                none_res);
        add_row(make_op(K_MUL, cmax, cmax, cmax, cmax, cmax, cmax, cmax, cmax, zr), 0,
                none_res);
        add_row(make_op(K_SCALE, cmin, cmax, t_comp'(-1), t_comp'(1), zr, zr, zr, zr, cmin),
                0, none_res);
        add_row(make_op(K_DIV, cmax, cmin, t_comp'(3), t_comp'(-3), zr, zr, zr, zr,
                        t_comp'(1)), 0, none_res);
        add_row(make_op(K_DIV, cmin, cmax, t_comp'(5), zr, zr, zr, zr, zr, t_comp'(-1)),
                0, none_res);
        add_row(make_op(K_DIV, t_comp'(1), t_comp'(-1), t_comp'(2), t_comp'(-2), zr, zr, zr,
                        zr, t_comp'(8192)), 0, none_res);
        add_row(make_op(K_NORM, t_comp'(1), zr, zr, zr, zr, zr, zr, zr, zr), 0, none_res);
        add_row(make_op(K_NORM, cmin, cmin, cmin, cmin, zr, zr, zr, zr, zr), 0, none_res);
        add_row(make_op(K_NORM, t_comp'(3), t_comp'(-4), zr, zr, zr, zr, zr, zr, zr), 0,
                none_res);
        add_row(make_op(K_INV, one, one, zr, zr, zr, zr, zr, zr, zr), 0, none_res);
        add_row(make_op(K_INV, t_comp'(46), t_comp'(-45), zr, zr, zr, zr, zr, zr, zr), 0,
                none_res);
        add_row(make_op(K_INV, cmax, cmin, cmax, cmin, zr, zr, zr, zr, zr), 0, none_res);
        add_row(make_op(K_INV, t_comp'(2), t_comp'(-1), zr, zr, zr, zr, zr, zr, zr), 0,
                none_res);

        // Directed part goes back to back so consecutive stages are all busy.
        foreach (directed_rows[i])
            send_op(directed_rows[i].op, directed_rows[i].has_expect,
                    directed_rows[i].expect_res);

        // Random part in bursts; some long runs with no gap at all.
        while (op_count < directed_rows.size() + RANDOM_OPS) begin
            burst = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 12);
            for (int i = 0; i < burst; i++) send_op(rand_op(), 0, none_res);
            idle_cycles($urandom_range(1, 6));
            if ($urandom_range(0, 15) == 0) idle_cycles($urandom_range(10, 60));
        end
        idle_cycles(1);

        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 20 * PIPE_DEPTH) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (PIPE_DEPTH + 5) @(posedge i_clk);

        $display("Sent %0d transactions covering all eight operation codes: %0d",
                 op_count, kind_seen.sum() with (int'(item)));
        $display("Checked %0d results, %0d mismatches, %0d left outstanding",
                 result_count, mismatch_count, pending_results.size());
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/qalu_pkg.sv
hw/rtl/qalu_front.sv
hw/rtl/qalu_sqrt.sv
hw/rtl/qalu_div.sv
hw/rtl/quaternion_alu_top.sv
verif/quaternion_alu_top_tb.sv
